### rtl/core/mwpo_pkg.sv
package mwpo_pkg;

  // fixed word formats
  localparam int PHASE_BITS   = 32;
  localparam int SAMPLE_BITS  = 16;
  localparam int SINE_ENTRIES = 256;
  localparam int SINE_IDX_BITS = $clog2(SINE_ENTRIES);

  localparam int BASE_W  = 19;
  localparam int SRATE_W = 18;
  localparam int CV_W    = 20;
  localparam int PM_W    = 16;
  localparam int SEL_W   = 16;
  localparam int HZ_W    = 19;
  localparam int DIVR_W  = SRATE_W + 4;
  localparam int CFG_DATA_W = 19;

  // frequency clamp and trigger thresholds
  localparam logic [HZ_W-1:0]         HZ_MAX   = 19'd320000;
  localparam logic signed [SEL_W-1:0] SEL_HIGH = 16'sd22938;
  localparam logic signed [SEL_W-1:0] SEL_LOW  = 16'sd9830;

  // 0.015 rad in turns, Q0.32
  localparam logic signed [24:0] PM_GAIN = 25'sd10253479;
  localparam int PM_SHIFT = 47 - PHASE_BITS;

  // quarter sine polynomial, Q30
  localparam int Q30_W = 31;
  localparam logic [Q30_W-1:0] Q30_ONE = 31'h4000_0000;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_BASE_FREQ   = 2'd0;
  localparam cfg_idx_t CFG_SAMPLE_RATE = 2'd1;
  localparam cfg_idx_t CFG_WAVEFORM    = 2'd2;

  typedef enum logic [1:0] {
    WAVE_SINE     = 2'd0,
    WAVE_TRIANGLE = 2'd1,
    WAVE_SAW      = 2'd2,
    WAVE_SQUARE   = 2'd3
  } wave_t;

  // horner coefficients, step 0 is the starting value
  function automatic logic [31:0] sine_coef(input logic [2:0] step);
    logic [31:0] c;
    unique case (step)
      3'd0:    c = 32'd3864;
      3'd1:    c = 32'd172272;
      3'd2:    c = 32'd5026995;
      3'd3:    c = 32'd85569306;
      3'd4:    c = 32'd693598668;
      3'd5:    c = 32'd1686629713;
      default: c = 32'd0;
    endcase
    return c;
  endfunction

endpackage

### rtl/core/mwpo_if.sv
interface mwpo_in_if
  import mwpo_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [CV_W-1:0]  freq_cv;
  logic signed [PM_W-1:0]  phase_mod;
  logic signed [SEL_W-1:0] wave_select;
  logic                    wave_select_present;

  modport source (output valid, freq_cv, phase_mod, wave_select, wave_select_present,
                  input ready);
  modport sink   (input valid, freq_cv, phase_mod, wave_select, wave_select_present,
                  output ready);
endinterface

interface mwpo_out_if
  import mwpo_pkg::*;
();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic [1:0]                    waveform_now;

  modport source (output valid, sample, waveform_now, input ready);
  modport sink   (input valid, sample, waveform_now, output ready);
endinterface

interface mwpo_cfg_if
  import mwpo_pkg::*;
();
  logic                  valid;
  logic                  ready;
  cfg_idx_t              index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/mwpo_div.sv
module mwpo_div
  import mwpo_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [HZ_W-1:0]       dividend,
  input  logic [DIVR_W-1:0]     divisor,
  output logic                  busy,
  output logic                  done,
  output logic [PHASE_BITS-1:0] quotient
);

  localparam int STEPS = HZ_W + PHASE_BITS;
  localparam int CNT_W = $clog2(STEPS);

  logic [DIVR_W-1:0]     rem_r;
  logic [DIVR_W-1:0]     div_r;
  logic [HZ_W-1:0]       num_r;
  logic [PHASE_BITS-1:0] quo_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  busy_r;
  logic                  done_r;

  logic [DIVR_W:0] trial;
  logic            ge;
  logic [DIVR_W:0] diff;

  // one restoring step: bring down the next dividend bit, try to subtract
  assign trial = {rem_r, num_r[HZ_W-1]};
  assign ge    = trial >= {1'b0, div_r};
  assign diff  = trial - {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == CNT_W'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      div_r <= divisor;
      num_r <= dividend;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
      num_r <= {num_r[HZ_W-2:0], 1'b0};
      quo_r <= {quo_r[PHASE_BITS-2:0], ge};
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

### rtl/core/mwpo_sine.sv
module mwpo_sine
  import mwpo_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [SINE_IDX_BITS-1:0]      index,
  output logic                          busy,
  output logic signed [SAMPLE_BITS-1:0] value
);

  localparam int REM_BITS = SINE_IDX_BITS - 2;
  localparam int X_SHIFT  = 30 - REM_BITS;
  localparam int RND_SH   = 30 - (SAMPLE_BITS - 1);
  localparam logic [SAMPLE_BITS:0] SAT_MAX = (SAMPLE_BITS+1)'((1 << (SAMPLE_BITS - 1)) - 1);

  logic [Q30_W-1:0]              x_r;
  logic [Q30_W-1:0]              x2_r;
  logic [31:0]                   acc_r;
  logic [1:0]                    quad_r;
  logic [2:0]                    step_r;
  logic                          busy_r;
  logic signed [SAMPLE_BITS-1:0] value_r;

  logic [Q30_W-1:0]   x_start;
  logic [Q30_W-1:0]   mul_a;
  logic [Q30_W-1:0]   mul_b;
  logic [2*Q30_W-1:0] prod;
  logic [31:0]        prod_sh;
  logic [31:0]        rnd;
  logic [SAMPLE_BITS:0] mag;
  logic [SAMPLE_BITS:0] mag_sat;

  // quadrant fold of the table index
  always_comb begin
    x_start = Q30_W'(index[REM_BITS-1:0]) << X_SHIFT;
    if (index[REM_BITS]) begin
      x_start = Q30_ONE - x_start;
    end
  end

  // shared multiplier: x*x first, then horner on acc, last acc*x
  assign mul_a   = (step_r == 3'd0) ? x_r : acc_r[Q30_W-1:0];
  assign mul_b   = (step_r >= 3'd1 && step_r <= 3'd5) ? x2_r : x_r;
  assign prod    = (2*Q30_W)'(mul_a) * (2*Q30_W)'(mul_b);
  assign prod_sh = prod[61:30];

  // round to the sample grid and saturate
  assign rnd     = acc_r + (32'd1 << (RND_SH - 1));
  assign mag     = rnd[RND_SH +: SAMPLE_BITS+1];
  assign mag_sat = (mag > SAT_MAX) ? SAT_MAX : mag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else begin
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        if (step_r == 3'd7) begin
          busy_r <= 1'b0;
        end
        step_r <= step_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= x_start;
      acc_r  <= sine_coef(3'd0);
      quad_r <= index[SINE_IDX_BITS-1 -: 2];
    end else if (busy_r) begin
      unique case (step_r)
        3'd0:    x2_r  <= prod_sh[Q30_W-1:0];
        3'd6:    acc_r <= prod_sh;
        3'd7:    value_r <= quad_r[1] ? -$signed(mag_sat[SAMPLE_BITS-1:0])
                                      :  $signed(mag_sat[SAMPLE_BITS-1:0]);
        default: acc_r <= sine_coef(step_r) - prod_sh;
      endcase
    end
  end

  assign busy  = busy_r;
  assign value = value_r;

endmodule

### rtl/core/multi_waveform_phase_oscillator_top.sv
// Multi-waveform phase oscillator: one audio sample per input word.
// in_ch carries freq_cv, phase_mod, wave_select and wave_select_present;
// out_ch returns sample (Q1.15) and waveform_now; cfg_ch writes base
// frequency (index 0), sample rate (index 1) and waveform (index 2, also
// loads the running waveform). cfg_ch is always ready; other indexes drop.
// A word is taken only while the block is idle. The wave-select trigger
// and waveform step act at once, the sample comes from the phase held
// before this word, and the phase then advances by the increment plus the phase_mod offset.
// The increment comes from a one-bit-per-cycle restoring divider over
// 19 + 32 = 51 steps; the sine is a seven-multiply Horner pass on one
// shared multiplier that runs in parallel and finishes first.
// The result is loaded into the output register when the divider is done,
// and the block goes idle with that load; no word is taken before then.
// A finished result waits in the output register while the next word is
// taken; if it is still not taken when the next result is done, the
// block holds until out_ch.ready.
// Reset: phase 0, sine selected, trigger disarmed, base 440 Hz, 48 kHz.
module multi_waveform_phase_oscillator_top
  import mwpo_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  mwpo_in_if.sink   in_ch,
  mwpo_out_if.source out_ch,
  mwpo_cfg_if.sink  cfg_ch
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BUSY,
    ST_HOLD
  } state_t;

  localparam int H = 1 << (SAMPLE_BITS - 1);

  state_t                        state_r;
  logic [BASE_W-1:0]             base_r;
  logic [SRATE_W-1:0]            srate_r;
  logic [1:0]                    wave_r;
  logic                          armed_r;
  logic [PHASE_BITS-1:0]         phase_r;
  logic [PHASE_BITS-1:0]         off_r;
  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] sample_r;
  logic [1:0]                    wave_now_r;

  logic                  in_acc;
  logic                  cfg_acc;
  logic                  load;
  logic [BASE_W-1:0]     base_c;
  logic signed [HZ_W+1:0] hz_sum;
  logic [HZ_W-1:0]       hz;
  logic [DIVR_W-1:0]     divisor;
  logic signed [40:0]    pm_prod;
  logic [PHASE_BITS-1:0] off_nxt;
  logic                  div_busy;
  logic                  div_done;
  logic [PHASE_BITS-1:0] inc;
  logic                  sine_busy;
  logic signed [SAMPLE_BITS-1:0] sine_val;
  logic [SAMPLE_BITS-1:0] t;
  logic signed [SAMPLE_BITS:0]   tri_d;
  logic [SAMPLE_BITS:0]          tri_abs;
  logic signed [SAMPLE_BITS+1:0] tri_v;
  logic signed [SAMPLE_BITS-1:0] sample_nxt;

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign cfg_acc = cfg_ch.valid && cfg_ch.ready;
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;

  // frequency clamp and divisor for the increment
  assign base_c  = (base_r > HZ_MAX) ? HZ_MAX : base_r;
  assign hz_sum  = $signed({2'b00, base_c}) + (HZ_W+2)'(in_ch.freq_cv);
  assign hz      = (hz_sum < 0) ? '0 :
                   (hz_sum > $signed({2'b00, HZ_MAX})) ? HZ_MAX : hz_sum[HZ_W-1:0];
  assign divisor = {((srate_r == '0) ? SRATE_W'(1) : srate_r), 4'b0000};

  // phase modulation offset, floor shift to the phase grid
  assign pm_prod = 41'(in_ch.phase_mod) * 41'(PM_GAIN);
  assign off_nxt = PHASE_BITS'($signed(pm_prod[40:PM_SHIFT]));

  mwpo_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_acc),
    .dividend (hz),
    .divisor  (divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (inc)
  );

  mwpo_sine u_sine (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_acc),
    .index (phase_r[PHASE_BITS-1 -: SINE_IDX_BITS]),
    .busy  (sine_busy),
    .value (sine_val)
  );

  // sample from the pre-update phase
  assign t       = phase_r[PHASE_BITS-1 -: SAMPLE_BITS];
  assign tri_d   = $signed({1'b0, t}) - (SAMPLE_BITS+1)'(H);
  assign tri_abs = tri_d[SAMPLE_BITS] ? (SAMPLE_BITS+1)'(-tri_d) : tri_d;
  assign tri_v   = (SAMPLE_BITS+2)'(H) - $signed({tri_abs, 1'b0});

  always_comb begin
    unique case (wave_t'(wave_r))
      WAVE_TRIANGLE: sample_nxt = (tri_v > (SAMPLE_BITS+2)'(H - 1)) ?
                                  SAMPLE_BITS'(H - 1) : tri_v[SAMPLE_BITS-1:0];
      WAVE_SAW:      sample_nxt = {~t[SAMPLE_BITS-1], t[SAMPLE_BITS-2:0]};
      WAVE_SQUARE:   sample_nxt = t[SAMPLE_BITS-1] ? SAMPLE_BITS'(-H) : SAMPLE_BITS'(H - 1);
      default:       sample_nxt = sine_val;
    endcase
  end

  // result leaves when the divider is done or a result is held, and the output register is free
  assign load = ((state_r == ST_BUSY && div_done) || state_r == ST_HOLD) &&
                (!out_valid_r || out_ch.ready);

  // sequencer, phase and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      base_r      <= BASE_W'(7040);
      srate_r     <= SRATE_W'(48000);
      wave_r      <= WAVE_SINE;
      armed_r     <= 1'b0;
      phase_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // configuration writes and the wave-select trigger
      if (cfg_acc && cfg_ch.index == CFG_BASE_FREQ) begin
        base_r <= cfg_ch.data[BASE_W-1:0];
      end
      if (cfg_acc && cfg_ch.index == CFG_SAMPLE_RATE) begin
        srate_r <= cfg_ch.data[SRATE_W-1:0];
      end
      if (cfg_acc && cfg_ch.index == CFG_WAVEFORM) begin
        wave_r <= cfg_ch.data[1:0];
      end else if (in_acc && in_ch.wave_select_present) begin
        if (!armed_r && in_ch.wave_select >= SEL_HIGH) begin
          wave_r  <= wave_r + 2'd1;
          armed_r <= 1'b1;
        end else if (armed_r && in_ch.wave_select <= SEL_LOW) begin
          armed_r <= 1'b0;
        end
      end

      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            state_r <= ST_BUSY;
          end
        end
        ST_BUSY: begin
          if (load) begin
            state_r <= ST_IDLE;
          end else if (div_done) begin
            state_r <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (load) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase

      if (load) begin
        phase_r <= phase_r + inc + off_r;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      off_r <= off_nxt;
    end
    if (load) begin
      sample_r   <= sample_nxt;
      wave_now_r <= wave_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.sample       = sample_r;
  assign out_ch.waveform_now = wave_now_r;

  // checks
  a_done_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_BUSY)
    else $error("divider finished outside of a busy item");

  a_sine_first: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> !sine_busy)
    else $error("sine pass still running when the increment is ready");

  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> !div_busy && !sine_busy)
    else $error("word taken while a previous word is in work");

  a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !load |=> $stable(phase_r))
    else $error("phase moved without a result");

endmodule

### test/tb_multi_waveform_phase_oscillator_top.sv
module tb_multi_waveform_phase_oscillator_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mwpo_pkg::*;

  // oscillator constants, own copy
  localparam longint           HZ_CEIL     = 320000;
  localparam longint           HALF_SCALE  = 32768;
  localparam longint           Q30_UNIT    = 64'sd1 << 30;
  localparam longint           PM_TURNS    = 10253479;
  localparam logic signed [15:0] ARM_LEVEL   = 16'sd22938;
  localparam logic signed [15:0] REARM_LEVEL = 16'sd9830;
  localparam cfg_idx_t         CFG_UNUSED  = 2'd3;

  typedef struct {
    logic signed [CV_W-1:0]  cv;
    logic signed [PM_W-1:0]  pm;
    logic signed [SEL_W-1:0] sel;
    logic                    sel_ok;
  } tick_t;

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] sample;
    wave_t                         wave;
  } tone_t;

  logic clk;
  logic rst_n;

  mwpo_in_if  in_ch();
  mwpo_out_if out_ch();
  mwpo_cfg_if cfg_ch();

  multi_waveform_phase_oscillator_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // oscillator state and registers as the block should hold them
  bit [BASE_W-1:0]  base_q4;
  bit [SRATE_W-1:0] rate_hz;
  bit [31:0]        phase_acc;
  wave_t            wave_cur;
  bit               trig_armed;

  tick_t       pending_ticks[$];
  tone_t       tone_q[$];
  int unsigned in_idle_pct;
  int unsigned out_stall_pct;
  int unsigned in_gap;
  int unsigned out_hold;
  logic        in_taken;
  int          err_count;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // sin(pi/2 * x), x and result in q30
  function automatic longint quarter_sine_q30(longint x);
    longint x2;
    longint acc;
    x2  = (x * x) >>> 30;
    acc = 3864;
    acc = 172272 - ((acc * x2) >>> 30);
    acc = 5026995 - ((acc * x2) >>> 30);
    acc = 85569306 - ((acc * x2) >>> 30);
    acc = 693598668 - ((acc * x2) >>> 30);
    acc = 1686629713 - ((acc * x2) >>> 30);
    return (acc * x) >>> 30;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] render_sample(bit [31:0] ph, wave_t w);
    longint   t;
    longint   d;
    longint   v;
    longint   x;
    bit [7:0] k;
    t = longint'(ph[31:16]);
    case (w)
      WAVE_TRIANGLE: begin
        d = t - HALF_SCALE;
        if (d < 0) d = -d;
        v = HALF_SCALE - 2 * d;
        if (v > HALF_SCALE - 1) v = HALF_SCALE - 1;
      end
      WAVE_SAW: v = t - HALF_SCALE;
      WAVE_SQUARE: v = (t < HALF_SCALE) ? HALF_SCALE - 1 : -HALF_SCALE;
      default: begin
        // table index, quadrant in the top two bits
        k = ph[31:24];
        x = longint'(k[5:0]) << 24;
        if (k[6]) x = Q30_UNIT - x;
        v = (quarter_sine_q30(x) * HALF_SCALE + (64'sd1 << 29)) >>> 30;
        if (v > HALF_SCALE - 1) v = HALF_SCALE - 1;
        if (k[7]) v = -v;
      end
    endcase
    return v[SAMPLE_BITS-1:0];
  endfunction

  // turns per sample for hz in q.4, zero rate counts as 1 hz
  function automatic bit [31:0] phase_step(longint hz);
    longint unsigned rate;
    longint unsigned num;
    rate = (rate_hz == 0) ? 1 : rate_hz;
    num  = longint'(hz) << 32;
    return 32'(num / (rate * 16));
  endfunction

  function automatic bit [31:0] mod_offset(logic signed [PM_W-1:0] pm);
    longint p;
    p = longint'(pm) * PM_TURNS;
    p = p >>> 15;
    return p[31:0];
  endfunction

  function automatic tone_t advance_oscillator(tick_t tk);
    tone_t  res;
    longint lim;
    longint hz;
    // schmitt trigger on wave select
    if (tk.sel_ok) begin
      if (!trig_armed && tk.sel >= ARM_LEVEL) begin
        wave_cur   = wave_t'(2'(wave_cur + 1));
        trig_armed = 1'b1;
      end else if (trig_armed && tk.sel <= REARM_LEVEL) begin
        trig_armed = 1'b0;
      end
    end
    res.wave   = wave_cur;
    res.sample = render_sample(phase_acc, wave_cur);
    // clamped frequency, then phase advance
    lim = (base_q4 > HZ_CEIL) ? HZ_CEIL : longint'(base_q4);
    hz  = lim + longint'(tk.cv);
    if (hz < 0) hz = 0;
    if (hz > HZ_CEIL) hz = HZ_CEIL;
    phase_acc = phase_acc + phase_step(hz) + mod_offset(tk.pm);
    return res;
  endfunction

  function automatic void flag_error(string what);
    err_count++;
    if (err_count <= 10) $display("mismatch: %s", what);
  endfunction

  function automatic void push_tick(int cv, int pm, int sel, bit ok);
    tick_t tk;
    tk.cv     = CV_W'(cv);
    tk.pm     = PM_W'(pm);
    tk.sel    = SEL_W'(sel);
    tk.sel_ok = ok;
    pending_ticks.push_back(tk);
  endfunction

  function automatic tick_t rand_tick();
    tick_t       tk;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 35) tk.cv = '0;
    else if (r < 70) tk.cv = CV_W'($urandom_range(4000) - 2000);
    else tk.cv = CV_W'($urandom_range(640000) - 320000);
    r = $urandom_range(99);
    if (r < 45) tk.pm = '0;
    else if (r < 70) tk.pm = PM_W'($urandom_range(1000) - 500);
    else tk.pm = PM_W'($urandom);
    // mostly trigger-shaped levels, some near the thresholds
    r = $urandom_range(99);
    if (r < 35) tk.sel = SEL_W'($urandom_range(32767, 22938));
    else if (r < 70) tk.sel = SEL_W'($urandom_range(9830 + 32768) - 32768);
    else if (r < 85) tk.sel = SEL_W'($urandom_range(22945, 22930));
    else if (r < 92) tk.sel = SEL_W'($urandom_range(9836, 9824));
    else tk.sel = SEL_W'($urandom);
    tk.sel_ok = ($urandom_range(99) < 80);
    return tk;
  endfunction

  // word source
  always @(negedge clk) begin : drive_ticks
    tick_t tk;
    if (rst_n && (!in_ch.valid || in_taken)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (pending_ticks.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
        tk = pending_ticks.pop_front();
        in_ch.valid               <= 1'b1;
        in_ch.freq_cv             <= tk.cv;
        in_ch.phase_mod           <= tk.pm;
        in_ch.wave_select         <= tk.sel;
        in_ch.wave_select_present <= tk.sel_ok;
      end else begin
        in_ch.valid <= 1'b0;
        if (in_idle_pct != 0 && $urandom_range(9) == 0) in_gap = $urandom_range(110, 20);
      end
    end
  end

  // sample sink backpressure
  always @(negedge clk) begin : drive_ready
    if (out_hold > 0) begin
      out_hold--;
      out_ch.ready <= 1'b0;
    end else if ($urandom_range(99) < out_stall_pct) begin
      out_ch.ready <= 1'b0;
      if ($urandom_range(9) == 0) out_hold = $urandom_range(110, 20);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // register writes, accepted words and returned samples
  always @(posedge clk) begin : watch_ports
    tone_t want;
    tick_t seen;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_ch.valid && in_ch.ready;
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_BASE_FREQ:   base_q4 = cfg_ch.data[BASE_W-1:0];
          CFG_SAMPLE_RATE: rate_hz = cfg_ch.data[SRATE_W-1:0];
          CFG_WAVEFORM:    wave_cur = wave_t'(cfg_ch.data[1:0]);
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        seen.cv     = in_ch.freq_cv;
        seen.pm     = in_ch.phase_mod;
        seen.sel    = in_ch.wave_select;
        seen.sel_ok = in_ch.wave_select_present;
        tone_q.push_back(advance_oscillator(seen));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (tone_q.size() == 0) begin
          flag_error($sformatf("sample %0d waveform %0d with no word pending",
                               out_ch.sample, out_ch.waveform_now));
        end else begin
          want = tone_q.pop_front();
          if (out_ch.sample !== want.sample || out_ch.waveform_now !== 2'(want.wave))
            flag_error($sformatf("got sample %0d waveform %0d, expected sample %0d waveform %0d",
                                 out_ch.sample, out_ch.waveform_now, want.sample,
                                 2'(want.wave)));
        end
      end
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (pending_ticks.size() != 0 || in_ch.valid || tone_q.size() != 0) @(posedge clk);
  endtask

  task automatic run_phase(int unsigned in_pct, int unsigned out_pct, int n);
    in_idle_pct   = in_pct;
    out_stall_pct = out_pct;
    repeat (n) pending_ticks.push_back(rand_tick());
    wait_drained();
  endtask

  initial begin
    rst_n                     = 1'b0;
    in_ch.valid               = 1'b0;
    in_ch.freq_cv             = '0;
    in_ch.phase_mod           = '0;
    in_ch.wave_select         = '0;
    in_ch.wave_select_present = 1'b0;
    out_ch.ready              = 1'b0;
    cfg_ch.valid              = 1'b0;
    cfg_ch.index              = CFG_BASE_FREQ;
    cfg_ch.data               = '0;
    base_q4                   = BASE_W'(7040);
    rate_hz                   = SRATE_W'(48000);
    phase_acc                 = '0;
    wave_cur                  = WAVE_SINE;
    trig_armed                = 1'b0;
    in_idle_pct               = 0;
    out_stall_pct             = 0;
    in_gap                    = 0;
    out_hold                  = 0;
    err_count                 = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: field extremes and a full trip through the waveforms
    push_tick(0, 0, 0, 1'b1);
    push_tick(320000, 0, 0, 1'b0);
    push_tick(-320000, 32767, 0, 1'b1);
    push_tick(0, -32768, -32768, 1'b1);
    push_tick(0, 0, 22937, 1'b1);
    push_tick(0, 0, 22938, 1'b1);
    push_tick(0, 0, 32767, 1'b1);
    push_tick(0, 0, 9831, 1'b1);
    push_tick(0, 0, 9830, 1'b1);
    push_tick(0, 0, 32767, 1'b0);
    push_tick(320000, 0, 32767, 1'b1);
    push_tick(0, 0, -32768, 1'b1);
    push_tick(320000, 0, 22938, 1'b1);
    push_tick(0, 0, 0, 1'b1);
    push_tick(-1, 0, 30000, 1'b1);
    push_tick(300000, 12345, -1, 1'b1);
    push_tick(250000, -1, 9830, 1'b1);
    push_tick(-7040, -12345, 32767, 1'b1);
    push_tick(123456, 32767, 0, 1'b1);
    push_tick(-123456, -32768, 22938, 1'b1);
    push_tick(319999, 1, 16384, 1'b1);
    push_tick(-319999, 21845, -21846, 1'b1);
    run_phase(0, 0, 80);

    // top of range, fast rate
    write_reg(CFG_BASE_FREQ, 19'd320000);
    write_reg(CFG_SAMPLE_RATE, 19'd192000);
    write_reg(CFG_WAVEFORM, 19'(WAVE_TRIANGLE));
    run_phase(47, 0, 100);

    // zero base, 1 hz rate, waveform with high data bits set; pause halfway
    write_reg(CFG_BASE_FREQ, 19'd0);
    write_reg(CFG_SAMPLE_RATE, 19'd1);
    write_reg(CFG_WAVEFORM, 19'h7FFFE);
    run_phase(0, 47, 50);
    run_phase(0, 47, 50);

    // base above the clamp, zero rate
    write_reg(CFG_BASE_FREQ, 19'h7FFFF);
    write_reg(CFG_SAMPLE_RATE, 19'd0);
    write_reg(CFG_WAVEFORM, 19'(WAVE_SQUARE));
    run_phase(33, 33, 100);

    // widest rate field, unused index dropped
    write_reg(CFG_BASE_FREQ, 19'd7040);
    write_reg(CFG_SAMPLE_RATE, 19'h7FFFF);
    write_reg(CFG_WAVEFORM, 19'(WAVE_SINE));
    write_reg(CFG_UNUSED, 19'd12345);
    run_phase(0, 0, 120);

    write_reg(CFG_BASE_FREQ, 19'($urandom_range(320000)));
    write_reg(CFG_SAMPLE_RATE, 19'd48000);
    run_phase(47, 0, 110);

    write_reg(CFG_BASE_FREQ, 19'd16000);
    write_reg(CFG_SAMPLE_RATE, 19'd44100);
    write_reg(CFG_WAVEFORM, 19'(WAVE_TRIANGLE));
    run_phase(0, 47, 110);

    write_reg(CFG_BASE_FREQ, 19'($urandom_range(320000)));
    write_reg(CFG_SAMPLE_RATE, 19'($urandom_range(192000, 1)));
    write_reg(CFG_WAVEFORM, 19'($urandom_range(3)));
    run_phase(33, 33, 110);

    // let any stray sample show up
    repeat (60) @(posedge clk);
    if (tone_q.size() != 0) flag_error($sformatf("%0d samples never returned", tone_q.size()));
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // run limit
  initial begin
    #8ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
